// ===== rtl/tlvp_pkg.sv =====
// Shared types and constants of the TLV command stream parser.
// No dependencies; every other file of the block imports or references this package.
package tlvp_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned LEN_W  = 16;

  // Type bytes seen outside a frame
  localparam logic [BYTE_W-1:0] BYTE_SWITCH_ON      = 8'h12;
  localparam logic [BYTE_W-1:0] BYTE_SWITCH_OFF     = 8'h13;
  localparam logic [BYTE_W-1:0] BYTE_SET_COLOR      = 8'h20;
  localparam logic [BYTE_W-1:0] BYTE_SET_BRIGHTNESS = 8'h21;

  typedef enum logic [1:0] {
    CMD_SWITCH_ON      = 2'd0,
    CMD_SWITCH_OFF     = 2'd1,
    CMD_SET_COLOR      = 2'd2,
    CMD_SET_BRIGHTNESS = 2'd3
  } cmd_code_t;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'b001,
    PH_LENGTH  = 3'b010,
    PH_PAYLOAD = 3'b100
  } phase_t;

  typedef struct packed {
    cmd_code_t         cmd_code;
    logic [BYTE_W-1:0] red;
    logic [BYTE_W-1:0] green;
    logic [BYTE_W-1:0] blue;
    logic [BYTE_W-1:0] level;
  } result_t;

endpackage

// ===== rtl/tlvp_if.sv =====
// Valid/ready channels of the parser: the byte stream in and the commands out.
// Depends on tlvp_pkg for field widths.
interface tlvp_in_if;
  logic                         valid;
  logic                         ready;
  logic [tlvp_pkg::BYTE_W-1:0]  in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface tlvp_out_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   cmd_code;
  logic [tlvp_pkg::BYTE_W-1:0]  red;
  logic [tlvp_pkg::BYTE_W-1:0]  green;
  logic [tlvp_pkg::BYTE_W-1:0]  blue;
  logic [tlvp_pkg::BYTE_W-1:0]  level;

  modport source (output valid, output cmd_code, output red, output green, output blue,
                  output level, input ready);
  modport sink   (input valid, input cmd_code, input red, input green, input blue,
                  input level, output ready);
endinterface

// ===== rtl/tlv_command_stream_parser_unit.sv =====
// TLV command stream parser: one stream byte per beat in, one command per beat out.
// Path: a byte that completes a command is held in the input register on acceptance,
// and its result loads into the result register once that register can take it.
// Throughput: one byte per cycle while the output is not stalled, as the decoder updates
// its phase once per accepted byte; back-pressure passes through both registers.
// Reset (synchronous, active high) empties both registers and returns the decoder to idle
// with the length, frame kind and payload tail cleared.
module tlv_command_stream_parser_unit #(
  parameter int unsigned LENGTH_BYTES = 2
) (
  input  logic        clk,
  input  logic        rst,
  tlvp_in_if.sink     stream,
  tlvp_out_if.source  result
);
  import tlvp_pkg::*;

  tlvp_in_if  held_byte ();
  tlvp_out_if decoded ();

  tlvp_in_stage u_in_stage (
    .clk    (clk),
    .rst    (rst),
    .sink   (stream),
    .source (held_byte)
  );

  tlvp_decoder #(
    .LENGTH_BYTES (LENGTH_BYTES)
  ) u_decoder (
    .clk    (clk),
    .rst    (rst),
    .sink   (held_byte),
    .source (decoded)
  );

  tlvp_out_stage u_out_stage (
    .clk    (clk),
    .rst    (rst),
    .sink   (decoded),
    .source (result)
  );

endmodule

// ===== rtl/tlvp_in_stage.sv =====
// Input register of the parser: holds one stream byte for the decoder.
// Depends on tlvp_pkg and tlvp_in_if.
module tlvp_in_stage (
  input  logic       clk,
  input  logic       rst,
  tlvp_in_if.sink    sink,
  tlvp_in_if.source  source
);
  import tlvp_pkg::*;

  logic              valid;
  logic [BYTE_W-1:0] data;

  // take a new beat whenever the held one leaves or none is held
  assign sink.ready     = !valid || source.ready;
  assign source.valid   = valid;
  assign source.in_byte = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (sink.ready) begin
      valid <= sink.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sink.valid && sink.ready) begin
      data <= sink.in_byte;
    end
  end

endmodule

// ===== rtl/tlvp_out_stage.sv =====
// Result register of the parser: holds one decoded command until taken.
// Depends on tlvp_pkg and tlvp_out_if.
module tlvp_out_stage (
  input  logic        clk,
  input  logic        rst,
  tlvp_out_if.sink    sink,
  tlvp_out_if.source  source
);
  import tlvp_pkg::*;

  logic    valid;
  result_t res;

  assign sink.ready      = !valid || source.ready;
  assign source.valid    = valid;
  assign source.cmd_code = res.cmd_code;
  assign source.red      = res.red;
  assign source.green    = res.green;
  assign source.blue     = res.blue;
  assign source.level    = res.level;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (sink.ready) begin
      valid <= sink.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sink.valid && sink.ready) begin
      res.cmd_code <= cmd_code_t'(sink.cmd_code);
      res.red      <= sink.red;
      res.green    <= sink.green;
      res.blue     <= sink.blue;
      res.level    <= sink.level;
    end
  end

endmodule

// ===== rtl/tlvp_decoder.sv =====
// Frame decoder: phase tracking, length and payload tail capture, result build.
// Depends on tlvp_pkg and the channel interfaces in tlvp_if.
module tlvp_decoder #(
  parameter int unsigned LENGTH_BYTES = 2
) (
  input  logic        clk,
  input  logic        rst,
  tlvp_in_if.sink     sink,
  tlvp_out_if.source  source
);
  import tlvp_pkg::*;

  localparam int unsigned CNT_W = $clog2(LENGTH_BYTES + 1);

  phase_t            phase, phase_next;
  logic              frame_kind, frame_kind_next;
  logic [LEN_W-1:0]  remaining, remaining_next;
  logic [BYTE_W-1:0] tail_bytes [3];
  logic [BYTE_W-1:0] tail_bytes_next [3];
  logic [CNT_W-1:0]  len_count, len_count_next;

  logic              beat;
  logic              finish;
  logic              emit;
  result_t           res;
  logic [LEN_W-1:0]  len_shift;
  logic [LEN_W-1:0]  rem_dec;

  // a beat leaves the input register only when the result register can take it
  assign sink.ready = source.ready;
  assign beat       = sink.valid && source.ready;

  assign len_shift = {remaining[LEN_W-BYTE_W-1:0], sink.in_byte};
  assign rem_dec   = remaining - 1'b1;

  always_comb begin
    phase_next         = phase;
    frame_kind_next    = frame_kind;
    remaining_next     = remaining;
    tail_bytes_next[0] = tail_bytes[0];
    tail_bytes_next[1] = tail_bytes[1];
    tail_bytes_next[2] = tail_bytes[2];
    len_count_next     = len_count;
    finish             = 1'b0;
    emit               = 1'b0;
    res                = '0;

    case (phase)
      PH_LENGTH: begin
        remaining_next = len_shift;
        len_count_next = len_count + 1'b1;
        if (len_count == CNT_W'(LENGTH_BYTES - 1)) begin
          len_count_next = '0;
          if (len_shift == '0) begin
            finish = 1'b1;
          end else begin
            phase_next = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        tail_bytes_next[2] = tail_bytes[1];
        tail_bytes_next[1] = tail_bytes[0];
        tail_bytes_next[0] = sink.in_byte;
        remaining_next     = rem_dec;
        if (rem_dec == '0) begin
          finish = 1'b1;
        end
      end
      default: begin
        phase_next = PH_IDLE;
        case (sink.in_byte)
          BYTE_SWITCH_ON: begin
            emit         = 1'b1;
            res.cmd_code = CMD_SWITCH_ON;
          end
          BYTE_SWITCH_OFF: begin
            emit         = 1'b1;
            res.cmd_code = CMD_SWITCH_OFF;
          end
          BYTE_SET_COLOR, BYTE_SET_BRIGHTNESS: begin
            frame_kind_next    = (sink.in_byte == BYTE_SET_BRIGHTNESS);
            remaining_next     = '0;
            len_count_next     = '0;
            tail_bytes_next[0] = '0;
            tail_bytes_next[1] = '0;
            tail_bytes_next[2] = '0;
            phase_next         = PH_LENGTH;
          end
          default: begin
            // skip unknown byte
          end
        endcase
      end
    endcase

    // a frame that ends reports from the updated tail, so short payloads read as zero
    if (finish) begin
      phase_next = PH_IDLE;
      emit       = 1'b1;
      if (frame_kind) begin
        res.cmd_code = CMD_SET_BRIGHTNESS;
        res.level    = tail_bytes_next[0];
      end else begin
        res.cmd_code = CMD_SET_COLOR;
        res.red      = tail_bytes_next[0];
        res.green    = tail_bytes_next[1];
        res.blue     = tail_bytes_next[2];
      end
    end
  end

  assign source.valid    = sink.valid && emit;
  assign source.cmd_code = res.cmd_code;
  assign source.red      = res.red;
  assign source.green    = res.green;
  assign source.blue     = res.blue;
  assign source.level    = res.level;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      frame_kind    <= 1'b0;
      remaining     <= '0;
      tail_bytes[0] <= '0;
      tail_bytes[1] <= '0;
      tail_bytes[2] <= '0;
      len_count     <= '0;
    end else if (beat) begin
      phase         <= phase_next;
      frame_kind    <= frame_kind_next;
      remaining     <= remaining_next;
      tail_bytes[0] <= tail_bytes_next[0];
      tail_bytes[1] <= tail_bytes_next[1];
      tail_bytes[2] <= tail_bytes_next[2];
      len_count     <= len_count_next;
    end
  end

endmodule
